>>> rtl/lmbs_pkg.sv
// ----------------------------------------------------------------------------
// lmbs_pkg
// Shared types, constants and helpers of the LED matrix brightness scanner.
// ----------------------------------------------------------------------------
package lmbs_pkg;

    localparam int LED_W      = 4;   // LED index field
    localparam int LEVEL_W    = 3;   // stored brightness level
    localparam int PAT_W      = 6;   // slot on-mask width
    localparam int NUM_LEVELS = 6;
    localparam int ANODE_W    = 3;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 6;
    localparam int IN_DATA_W  = 8;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 8;

    localparam logic [LEVEL_W-1:0] MAX_LEVEL = 3'd5;

    typedef logic [IN_USER_W-1:0] opcode_t;
    localparam opcode_t OP_SCAN  = 2'd0;
    localparam opcode_t OP_WRITE = 2'd1;
    localparam opcode_t OP_SWAP  = 2'd2;

    typedef logic [PAT_W-1:0] pattern_t;
    typedef pattern_t [NUM_LEVELS-1:0] pattern_bank_t;

    localparam pattern_bank_t PATTERN_RESET = '{
        6'd31, 6'd27, 6'd21, 6'd10, 6'd4, 6'd0
    };

    // Request from the scan control to the frame buffer
    typedef struct packed {
        logic               wr_en;
        logic               swap;
        logic               rd_en;
        logic [LED_W-1:0]   led;
        logic [LEVEL_W-1:0] level;
    } fb_req_t;

    function automatic logic [LEVEL_W-1:0] sat_level(input logic [LEVEL_W-1:0] v);
        sat_level = (v > MAX_LEVEL) ? MAX_LEVEL : v;
    endfunction

endpackage

>>> rtl/lmbs_frame_buf.sv
// ----------------------------------------------------------------------------
// lmbs_frame_buf
// Double frame buffer of brightness levels: the back buffer is written,
// the front buffer is read through a register, swap flips the roles.
// ----------------------------------------------------------------------------
module lmbs_frame_buf #(
    parameter int NUM_LEDS = 16
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  lmbs_pkg::fb_req_t         req,
    output logic [lmbs_pkg::LEVEL_W-1:0] rd_level
);
    import lmbs_pkg::*;

    localparam int DEPTH  = 2 * NUM_LEDS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [LEVEL_W-1:0] mem [DEPTH];
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic               front_reg;
    logic               front_next;
    logic [LEVEL_W-1:0] rd_data_reg;
    logic               rd_hit_reg;
    logic [ADDR_W-1:0]  waddr;
    logic [ADDR_W-1:0]  raddr;
    logic               wr_ok;

    assign waddr = (front_reg ? ADDR_W'(0) : ADDR_W'(NUM_LEDS)) + ADDR_W'(req.led);
    assign raddr = (front_reg ? ADDR_W'(NUM_LEDS) : ADDR_W'(0)) + ADDR_W'(req.led);
    // drop writes to LEDs that do not exist
    assign wr_ok = req.wr_en && (32'(req.led) < NUM_LEDS);

    always_comb
    begin
        valid_next = valid_reg;
        if (wr_ok)
        begin
            valid_next[waddr] = 1'b1;
        end
        front_next = req.swap ? ~front_reg : front_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            front_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            front_reg <= front_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_ok)
        begin
            mem[waddr] <= sat_level(req.level);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rd_en)
        begin
            rd_data_reg <= mem[raddr];
            rd_hit_reg  <= valid_reg[raddr];
        end
    end

    // entries never written since reset read as level zero
    assign rd_level = rd_hit_reg ? sat_level(rd_data_reg) : '0;

endmodule

>>> rtl/led_matrix_brightness_scanner_unit.sv
// ----------------------------------------------------------------------------
// led_matrix_brightness_scanner_unit
// Multiplexed LED matrix driver with per-LED brightness by time slots.
// ----------------------------------------------------------------------------
// One input transaction is taken every clock unless the output stalls.
// Writes and swaps take effect at acceptance and give no output; a scan
// tick gives one output transaction through the synchronous frame buffer
// read of the front buffer, then the slot-mask lookup into the output
// register. The scan position runs as an LED counter and a slot counter, so
// a full frame is NUM_LEDS * NUM_SLOTS scan ticks. The frame buffers clear
// at reset through per-entry valid flags, so no clearing pass is needed.
module led_matrix_brightness_scanner_unit #(
    parameter int NUM_LEDS  = 16,
    parameter int NUM_SLOTS = 6
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // slave side
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lmbs_pkg::IN_DATA_W-1:0]      s_tdata,  // led_index[3:0], level[6:4]
    input  logic [lmbs_pkg::IN_USER_W-1:0]      s_tuser,  // opcode[1:0]
    // master side
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lmbs_pkg::OUT_DATA_W-1:0]     m_tdata,  // anode_select[2:0],
                                                          // cathode_low[3],
                                                          // cathode_high[4],
                                                          // anode_disable[5]
    // configuration
    input  logic                                cfg_wr_en,
    input  logic [lmbs_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [lmbs_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import lmbs_pkg::*;

    localparam int SLOT_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    pattern_bank_t        pattern_reg;
    pattern_bank_t        pattern_next;

    logic [LED_W-1:0]     led_cnt_reg;
    logic [LED_W-1:0]     led_cnt_next;
    logic [SLOT_W-1:0]    slot_cnt_reg;
    logic [SLOT_W-1:0]    slot_cnt_next;

    logic                 s1_valid_reg;
    logic                 s1_valid_next;
    logic [LED_W-1:0]     s1_led_reg;
    logic [SLOT_W-1:0]    s1_slot_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic [ANODE_W-1:0]   last_anode_reg;
    logic [ANODE_W-1:0]   last_anode_next;

    opcode_t              opcode;
    logic [LED_W-1:0]     in_led;
    logic [LEVEL_W-1:0]   in_level;
    logic                 accept;
    logic                 scan_acc;
    logic                 s1_go;
    fb_req_t              fb_req;
    logic [LEVEL_W-1:0]   rd_level;
    pattern_t             pat;
    logic [2:0]           slot_ext;
    logic                 lit;

    assign opcode   = s_tuser;
    assign in_led   = s_tdata[LED_W-1:0];
    assign in_level = s_tdata[LED_W+LEVEL_W-1:LED_W];

    assign s1_go    = !out_valid_reg || m_tready;
    assign s_tready = !s1_valid_reg || s1_go;
    assign accept   = s_tvalid && s_tready;
    assign scan_acc = accept && (opcode == OP_SCAN);

    always_comb
    begin
        fb_req.wr_en = accept && (opcode == OP_WRITE);
        fb_req.swap  = accept && (opcode == OP_SWAP);
        fb_req.rd_en = scan_acc;
        fb_req.led   = scan_acc ? led_cnt_reg : in_led;
        fb_req.level = in_level;
    end

    lmbs_frame_buf #(
        .NUM_LEDS (NUM_LEDS)
    ) u_frame_buf (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (fb_req),
        .rd_level (rd_level)
    );

    // configuration writes; indexes beyond the list are dropped
    always_comb
    begin
        pattern_next = pattern_reg;
        if (cfg_wr_en && (32'(cfg_index) < NUM_LEVELS))
        begin
            pattern_next[cfg_index] = cfg_data;
        end
    end

    // scan position: advance LED, then slot, wrap at end of frame
    always_comb
    begin
        led_cnt_next  = led_cnt_reg;
        slot_cnt_next = slot_cnt_reg;
        if (scan_acc)
        begin
            if (led_cnt_reg == LED_W'(NUM_LEDS - 1))
            begin
                led_cnt_next  = '0;
                slot_cnt_next = (slot_cnt_reg == SLOT_W'(NUM_SLOTS - 1)) ?
                                '0 : slot_cnt_reg + SLOT_W'(1);
            end
            else
            begin
                led_cnt_next = led_cnt_reg + LED_W'(1);
            end
        end
    end

    // slot-mask lookup on the level read back from the front buffer
    assign pat      = pattern_reg[rd_level];
    assign slot_ext = 3'(s1_slot_reg);
    assign lit      = (slot_ext < 3'(PAT_W)) ? pat[slot_ext] : 1'b0;

    always_comb
    begin
        s1_valid_next   = s1_valid_reg;
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        last_anode_next = last_anode_reg;
        // load the read stage whenever it can take a transaction
        if (s_tready)
        begin
            s1_valid_next = scan_acc;
        end
        if (s1_go)
        begin
            out_valid_next = s1_valid_reg;
            if (s1_valid_reg)
            begin
                if (lit)
                begin
                    last_anode_next = s1_led_reg[ANODE_W-1:0];
                    out_data_next   = {2'b00, 1'b0, s1_led_reg[LED_W-1],
                                       ~s1_led_reg[LED_W-1],
                                       s1_led_reg[ANODE_W-1:0]};
                end
                else
                begin
                    // blank: hold anode lines, release both cathodes
                    out_data_next = {2'b00, 1'b1, 1'b0, 1'b0, last_anode_reg};
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pattern_reg    <= PATTERN_RESET;
            led_cnt_reg    <= '0;
            slot_cnt_reg   <= '0;
            s1_valid_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
            last_anode_reg <= '0;
        end
        else
        begin
            pattern_reg    <= pattern_next;
            led_cnt_reg    <= led_cnt_next;
            slot_cnt_reg   <= slot_cnt_next;
            s1_valid_reg   <= s1_valid_next;
            out_valid_reg  <= out_valid_next;
            last_anode_reg <= last_anode_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
        if (scan_acc)
        begin
            s1_led_reg  <= led_cnt_reg;
            s1_slot_reg <= slot_cnt_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule
